// ===== rtl/sctc_pkg.sv =====
// ============================================================================
// sctc_pkg: shared types, codes and tables of the set-1 keyboard byte handler
// Holds the result kinds, key codes, translation tables and the job record
// that travels from the classifying front to the result emitter.
// ============================================================================
`default_nettype none

package sctc_pkg;

    // Command queue geometry (depth must be a power of two)
    localparam int QUEUE_DEPTH = 32;
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QIDX_W + 1;

    // Job queue between front and back
    localparam int JOBQ_DEPTH  = 4;
    localparam int JIDX_W      = $clog2(JOBQ_DEPTH);
    localparam int JCNT_W      = JIDX_W + 1;

    // Result kinds
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_KBD      = 2'd1;
    localparam logic [1:0] KIND_HOTKEY   = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    // Hotkey codes
    localparam logic [7:0] HK_TAB  = 8'd0;
    localparam logic [7:0] HK_F11  = 8'd1;
    localparam logic [7:0] HK_KILL = 8'd2;
    localparam logic [7:0] HK_NEW  = 8'd3;

    // Scan codes and keyboard bytes
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
    localparam logic [7:0] SC_CAPS         = 8'h3a;
    localparam logic [7:0] SC_NUM          = 8'h45;
    localparam logic [7:0] SC_SCROLL       = 8'h46;
    localparam logic [7:0] SC_F1           = 8'h3b;
    localparam logic [7:0] SC_F2           = 8'h3c;
    localparam logic [7:0] SC_TAB          = 8'h0f;
    localparam logic [7:0] SC_F11          = 8'h57;
    localparam logic [7:0] KBD_ACK         = 8'hfa;
    localparam logic [7:0] KBD_RESEND      = 8'hfe;
    localparam logic [7:0] LED_CMD         = 8'hed;

    // Lock bit masks
    localparam logic [2:0] LOCK_CAPS   = 3'b100;
    localparam logic [2:0] LOCK_NUM    = 3'b010;
    localparam logic [2:0] LOCK_SCROLL = 3'b001;

    // Letter range and case offset
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_CASE    = 8'h20;

    // Plain translation table
    localparam logic [7:0] PLAIN_MAP [128] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
        8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
    };

    // Shifted translation table
    localparam logic [7:0] SHIFT_MAP [128] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h08, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
        8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
    };

    // One classified item: an optional byte to the keyboard, then an
    // optional second result
    typedef struct packed {
        logic       send_v;
        logic [7:0] send_byte;
        logic       sec_v;
        logic [1:0] sec_kind;
        logic [7:0] sec_value;
    } job_t;

endpackage

`default_nettype wire

// ===== rtl/sctc_front.sv =====
// ============================================================================
// sctc_front: keyboard byte classifier
// Accepts one raw byte per cycle while the job queue has room, keeps shift,
// lock, acknowledge and command queue state, and hands jobs to the job queue.
// ============================================================================
`default_nettype none

module sctc_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start_leds_we,
    input  wire logic [2:0]          start_leds,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          scan_code,
    input  wire logic                focus_present,
    input  wire logic                jobq_full,
    output logic                     job_push,
    output sctc_pkg::job_t           job_data
);

    logic [2:0]                   start_reg;
    logic [1:0]                   shift_reg, shift_next;
    logic [2:0]                   lock_reg, lock_next;
    logic                         await_reg, await_next;
    logic [7:0]                   awaited_reg, awaited_next;
    logic [sctc_pkg::QIDX_W-1:0]  head_reg, head_next;
    logic [sctc_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic [1:0]                   fresh_reg, fresh_next;
    logic [7:0]                   q_mem [sctc_pkg::QUEUE_DEPTH];
    logic [7:0]                   q_rd_reg;

    logic                         accept;
    logic                         q_wr;
    logic [sctc_pkg::QIDX_W-1:0]  rd_addr;
    logic                         pop;
    logic [7:0]                   head_byte;
    logic [sctc_pkg::QCNT_W-1:0]  count_pop;
    logic [sctc_pkg::QIDX_W-1:0]  head_pop;
    logic                         toggle;
    logic [2:0]                   lock_mask;
    logic                         wr0, wr1;
    logic [sctc_pkg::QIDX_W-1:0]  wa0, wa1;
    logic                         overflow;
    logic [7:0]                   ch;
    logic                         sec_v;
    logic [1:0]                   sec_kind;
    logic [7:0]                   sec_value;

    // Take a byte whenever the job queue has room
    assign in_stall = jobq_full;
    assign accept   = in_valid && !jobq_full;
    assign q_wr     = accept && !start_leds_we;

    // Read the queue head from the registered read; the two start-up
    // entries live in registers
    always_comb
    begin
        if (fresh_reg[0] && head_reg == '0)
        begin
            head_byte = sctc_pkg::LED_CMD;
        end
        else if (fresh_reg[1] && head_reg == sctc_pkg::QIDX_W'(1))
        begin
            head_byte = {5'b0, start_reg};
        end
        else
        begin
            head_byte = q_rd_reg;
        end
    end

    // Classify the byte and work out the next state
    always_comb
    begin
        pop          = (count_reg != '0) && !await_reg;
        count_pop    = count_reg - sctc_pkg::QCNT_W'(pop);
        head_pop     = head_reg + sctc_pkg::QIDX_W'(pop);
        await_next   = await_reg || pop;
        awaited_next = pop ? head_byte : awaited_reg;

        // Track shift keys
        shift_next = shift_reg;
        case (scan_code)
            sctc_pkg::SC_LSHIFT_MAKE:  shift_next = shift_reg | 2'b01;
            sctc_pkg::SC_RSHIFT_MAKE:  shift_next = shift_reg | 2'b10;
            sctc_pkg::SC_LSHIFT_BREAK: shift_next = shift_reg & 2'b10;
            sctc_pkg::SC_RSHIFT_BREAK: shift_next = shift_reg & 2'b01;
            default:                   shift_next = shift_reg;
        endcase

        // Decode lock keys
        case (scan_code)
            sctc_pkg::SC_CAPS:   lock_mask = sctc_pkg::LOCK_CAPS;
            sctc_pkg::SC_NUM:    lock_mask = sctc_pkg::LOCK_NUM;
            sctc_pkg::SC_SCROLL: lock_mask = sctc_pkg::LOCK_SCROLL;
            default:             lock_mask = 3'b000;
        endcase
        toggle    = (lock_mask != 3'b000);
        lock_next = lock_reg ^ lock_mask;

        // Push the LED command pair, dropping what does not fit
        wr0      = toggle && (count_pop < sctc_pkg::QCNT_W'(sctc_pkg::QUEUE_DEPTH));
        wr1      = toggle && (count_pop < sctc_pkg::QCNT_W'(sctc_pkg::QUEUE_DEPTH - 1));
        overflow = toggle && !wr1;
        wa0      = head_pop + count_pop[sctc_pkg::QIDX_W-1:0];
        wa1      = wa0 + sctc_pkg::QIDX_W'(1);
        count_next = count_pop + sctc_pkg::QCNT_W'(wr0) + sctc_pkg::QCNT_W'(wr1);
        head_next  = head_pop;

        // Drop the start-up marks once their entries are rewritten
        fresh_next = fresh_reg;
        if ((wr0 && wa0 == '0) || (wr1 && wa1 == '0))
        begin
            fresh_next[0] = 1'b0;
        end
        if ((wr0 && wa0 == sctc_pkg::QIDX_W'(1)) || (wr1 && wa1 == sctc_pkg::QIDX_W'(1)))
        begin
            fresh_next[1] = 1'b0;
        end

        // Translate make codes and fix the letter case
        if (scan_code[7])
        begin
            ch = 8'h00;
        end
        else if (shift_next == 2'b00)
        begin
            ch = sctc_pkg::PLAIN_MAP[scan_code[6:0]];
        end
        else
        begin
            ch = sctc_pkg::SHIFT_MAP[scan_code[6:0]];
        end
        if (ch >= sctc_pkg::CH_UPPER_A && ch <= sctc_pkg::CH_UPPER_Z
            && (lock_next[2] == (shift_next != 2'b00)))
        begin
            ch = ch + sctc_pkg::CH_CASE;
        end

        // Pick the second result; at most one applies to a given byte
        sec_v     = 1'b0;
        sec_kind  = sctc_pkg::KIND_CHAR;
        sec_value = 8'h00;
        case (scan_code)
            sctc_pkg::SC_F11:
            begin
                sec_v     = 1'b1;
                sec_kind  = sctc_pkg::KIND_HOTKEY;
                sec_value = sctc_pkg::HK_F11;
            end
            sctc_pkg::SC_CAPS, sctc_pkg::SC_NUM, sctc_pkg::SC_SCROLL:
            begin
                sec_v     = overflow;
                sec_kind  = sctc_pkg::KIND_OVERFLOW;
            end
            sctc_pkg::KBD_ACK:
            begin
                await_next = 1'b0;
            end
            sctc_pkg::KBD_RESEND:
            begin
                sec_v     = await_next;
                sec_kind  = sctc_pkg::KIND_KBD;
                sec_value = awaited_next;
            end
            sctc_pkg::SC_F1:
            begin
                sec_v     = (shift_next != 2'b00) && focus_present;
                sec_kind  = sctc_pkg::KIND_HOTKEY;
                sec_value = sctc_pkg::HK_KILL;
            end
            sctc_pkg::SC_F2:
            begin
                sec_v     = (shift_next != 2'b00);
                sec_kind  = sctc_pkg::KIND_HOTKEY;
                sec_value = sctc_pkg::HK_NEW;
            end
            sctc_pkg::SC_TAB:
            begin
                sec_v     = focus_present;
                sec_kind  = sctc_pkg::KIND_HOTKEY;
                sec_value = sctc_pkg::HK_TAB;
            end
            default:
            begin
                sec_v     = (ch != 8'h00) && focus_present;
                sec_kind  = sctc_pkg::KIND_CHAR;
                sec_value = ch;
            end
        endcase
    end

    // Read the entry that is the head after this edge
    assign rd_addr = start_leds_we ? '0 : (accept ? head_next : head_reg);

    // Hand the job over when it carries at least one result
    assign job_push            = accept && (pop || sec_v);
    assign job_data.send_v     = pop;
    assign job_data.send_byte  = head_byte;
    assign job_data.sec_v      = sec_v;
    assign job_data.sec_kind   = sec_kind;
    assign job_data.sec_value  = sec_value;

    // Update state on a restart or an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= 3'b000;
            shift_reg   <= 2'b00;
            lock_reg    <= 3'b000;
            await_reg   <= 1'b0;
            awaited_reg <= 8'h00;
            head_reg    <= '0;
            count_reg   <= sctc_pkg::QCNT_W'(2);
            fresh_reg   <= 2'b11;
        end
        else if (start_leds_we)
        begin
            start_reg   <= start_leds;
            shift_reg   <= 2'b00;
            lock_reg    <= start_leds;
            await_reg   <= 1'b0;
            awaited_reg <= 8'h00;
            head_reg    <= '0;
            count_reg   <= sctc_pkg::QCNT_W'(2);
            fresh_reg   <= 2'b11;
        end
        else if (accept)
        begin
            shift_reg   <= shift_next;
            lock_reg    <= lock_next;
            await_reg   <= await_next;
            awaited_reg <= awaited_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
        end
    end

    // Write queued command bytes and register the next head entry,
    // passing a byte written to that entry straight through
    always_ff @(posedge clk)
    begin
        if (q_wr)
        begin
            if (wr0)
            begin
                q_mem[wa0] <= sctc_pkg::LED_CMD;
            end
            if (wr1)
            begin
                q_mem[wa1] <= {5'b0, lock_next};
            end
        end
        if (q_wr && wr0 && wa0 == rd_addr)
        begin
            q_rd_reg <= sctc_pkg::LED_CMD;
        end
        else if (q_wr && wr1 && wa1 == rd_addr)
        begin
            q_rd_reg <= {5'b0, lock_next};
        end
        else
        begin
            q_rd_reg <= q_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sctc_jobq.sv =====
// ============================================================================
// sctc_jobq: job queue between classifier and emitter
// Small first-in first-out buffer of job records so that front and back
// stall independently.
// ============================================================================
`default_nettype none

module sctc_jobq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire sctc_pkg::job_t   push_data,
    output logic                  full,
    input  wire logic             pop,
    output sctc_pkg::job_t        head_data,
    output logic                  empty
);

    sctc_pkg::job_t               slot [sctc_pkg::JOBQ_DEPTH];
    logic [sctc_pkg::JIDX_W-1:0]  rd_reg, rd_next;
    logic [sctc_pkg::JIDX_W-1:0]  wr_reg, wr_next;
    logic [sctc_pkg::JCNT_W-1:0]  cnt_reg, cnt_next;

    assign full      = (cnt_reg == sctc_pkg::JCNT_W'(sctc_pkg::JOBQ_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign head_data = slot[rd_reg];

    // Advance pointers and count
    always_comb
    begin
        rd_next  = rd_reg + sctc_pkg::JIDX_W'(pop);
        wr_next  = wr_reg + sctc_pkg::JIDX_W'(push);
        cnt_next = cnt_reg + sctc_pkg::JCNT_W'(push) - sctc_pkg::JCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sctc_back.sv =====
// ============================================================================
// sctc_back: result emitter
// Turns each job into one or two result beats and holds them in an output
// register until the receiver takes them.
// ============================================================================
`default_nettype none

module sctc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sctc_pkg::job_t   job,
    input  wire logic             job_empty,
    output logic                  job_pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [1:0]            kind,
    output logic [7:0]            value,
    output logic                  last
);

    logic       valid_reg, valid_next;
    logic       phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] value_reg, value_next;
    logic       last_reg, last_next;
    logic       load;

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign last      = last_reg;

    // Refill the output register when it is empty or being taken
    assign load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        value_next = value_reg;
        last_next  = last_reg;
        job_pop    = 1'b0;
        if (load)
        begin
            valid_next = !job_empty;
            if (!job_empty)
            begin
                if (job.send_v && !phase_reg)
                begin
                    // Byte to the keyboard first
                    kind_next  = sctc_pkg::KIND_KBD;
                    value_next = job.send_byte;
                    last_next  = !job.sec_v;
                    phase_next = job.sec_v;
                    job_pop    = !job.sec_v;
                end
                else
                begin
                    // Then the second result
                    kind_next  = job.sec_kind;
                    value_next = job.sec_value;
                    last_next  = 1'b1;
                    phase_next = 1'b0;
                    job_pop    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    // Hold the beat payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/scancode_to_char_with_lock_leds.sv =====
// ============================================================================
// scancode_to_char_with_lock_leds: set-1 keyboard byte handler with lock LEDs
// Translates raw keyboard bytes into characters and hotkeys, tracks shift and
// lock keys, and paces LED command bytes to the keyboard against its acks.
// ============================================================================
//
//  channel  | handshake                | beat contents
//  ---------+--------------------------+-----------------------------------
//  config   | start_leds_we            | start_leds
//  input    | in_valid / in_stall      | scan_code, focus_present
//  output   | out_valid / out_stall    | kind, value, last
//
//  The front takes one input beat per cycle while the job queue has room and
//  classifies it in that cycle. Each item yields zero, one or two result
//  beats; the back emits one per cycle while the receiver does not stall.
//  A four-entry job queue lets the input run on while results stall.
//  Reset and a start_leds write restart the state with 0xED and the lock
//  bits pending as the first keyboard bytes.
//
`default_nettype none

module scancode_to_char_with_lock_leds (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start_leds_we,
    input  wire logic [2:0] start_leds,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] scan_code,
    input  wire logic       focus_present,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      value,
    output logic            last
);

    logic           jobq_full;
    logic           jobq_empty;
    logic           job_push;
    logic           job_pop;
    sctc_pkg::job_t job_in;
    sctc_pkg::job_t job_head;

    // Classify incoming beats
    sctc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_leds_we (start_leds_we),
        .start_leds    (start_leds),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .scan_code     (scan_code),
        .focus_present (focus_present),
        .jobq_full     (jobq_full),
        .job_push      (job_push),
        .job_data      (job_in)
    );

    // Buffer jobs between the two sides
    sctc_jobq u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (job_in),
        .full      (jobq_full),
        .pop       (job_pop),
        .head_data (job_head),
        .empty     (jobq_empty)
    );

    // Emit result beats
    sctc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_head),
        .job_empty (jobq_empty),
        .job_pop   (job_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .value     (value),
        .last      (last)
    );

endmodule

`default_nettype wire
